// ===== design/ebin_pkg.sv =====
// ebin_pkg: shared constants, types and helpers for the echogram energy binner
// no dependencies; imported by every module of the block
`default_nettype none
package ebin_pkg;

    // store geometry
    localparam int MAX_BINS  = 1024;
    localparam int MAX_BANDS = 8;
    localparam int DEPTH     = MAX_BANDS * MAX_BINS;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int BIN_W     = $clog2(MAX_BINS);
    localparam int CNT_W     = ($clog2(MAX_BINS + 1) > 11) ? $clog2(MAX_BINS + 1) : 11;
    localparam int BCNT_W    = 6;
    localparam int HEXT_W    = (BIN_W > 10) ? BIN_W : 10;

    // field widths
    localparam int VAL_W  = 48;
    localparam int WORD_W = 32;
    localparam int DIV_W  = 32;
    localparam int STEP_W = $clog2(DIV_W);

    typedef enum logic [1:0] {
        ACT_ACCUM = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NOP   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CFG_BIN_WIDTH  = 2'd0,
        CFG_BIN_COUNT  = 2'd1,
        CFG_BAND_COUNT = 2'd2
    } t_cfg_index;

    // divider request and response
    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIV_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quotient;
    } t_div_rsp;

    // store write port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [VAL_W-1:0]  data;
    } t_mem_wr;

    // highest mark as shown at the port, saturating at 1023
    function automatic logic [9:0] hi_out(input logic [BIN_W-1:0] h);
        logic [HEXT_W-1:0] ext;
        ext = HEXT_W'(h);
        return (ext > HEXT_W'(1023)) ? 10'd1023 : ext[9:0];
    endfunction

endpackage
`default_nettype wire

// ===== design/ebin_divider.sv =====
// ebin_divider: restoring radix-2 divider, one quotient bit per cycle
// depends on ebin_pkg; a zero divisor yields an all-ones quotient
`default_nettype none
module ebin_divider
    import ebin_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_num;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_den;

    logic [DIV_W:0]    shifted;
    logic [DIV_W:0]    diff;
    logic              ge;
    logic [DIV_W-1:0]  n_rem;

    // one trial subtraction
    always_comb begin
        shifted = {r_rem, r_num[DIV_W-1]};
        diff    = shifted - {1'b0, r_den};
        ge      = shifted >= {1'b0, r_den};
        n_rem   = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
    end

    // step sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(DIV_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: quotient bits shift in from the bottom
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_num;

endmodule
`default_nettype wire

// ===== design/ebin_store.sv =====
// ebin_store: echogram bin memory, one write and one registered read port
// depends on ebin_pkg for depth and widths
`default_nettype none
module ebin_store
    import ebin_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_mem_wr           i_wr,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic [VAL_W-1:0]       o_rd_data
);

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ===== design/echogram_energy_binner_core.sv =====
// echogram_energy_binner_core: per-band time-binned energy echogram, top level
// result word: a direct hit takes one pass of the shared radix-2 divider and a divided hit two;
// a hit past the last bin is dropped after its first pass, a clear sweeps the whole store
// throughput: one word at a time; the next word is taken the cycle after its result is
// registered; a stalled result delays it
// reset: synchronous; then a clearing pass over the whole store, no input meanwhile (config taken)
`default_nettype none
module echogram_energy_binner_core
    import ebin_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_action,
    input  wire logic [2:0]  i_band,
    input  wire logic [31:0] i_arrival_time,
    input  wire logic [31:0] i_path_distance,
    input  wire logic [31:0] i_hit_energy,
    input  wire logic [15:0] i_ray_hit_count,
    input  wire logic [9:0]  i_read_bin,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [47:0]      o_bin_value,
    output logic [9:0]       o_highest_bin,
    output logic             o_accepted
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV_T,
        ST_DIV_E,
        ST_RD,
        ST_USE,
        ST_EMIT
    } t_state;

    t_state              r_state;
    logic [WORD_W-1:0]   r_bin_width;
    logic [10:0]         r_bin_count;
    logic [3:0]          r_band_count;

    t_action             r_op;
    logic [WORD_W-1:0]   r_dist;
    logic [WORD_W-1:0]   r_energy;
    logic [15:0]         r_hits;
    logic [2:0]          r_band;
    logic [BIN_W-1:0]    r_bin;
    logic [ADDR_W-1:0]   r_addr;
    logic [WORD_W-1:0]   r_add;
    logic [BIN_W-1:0]    r_highest;
    logic [ADDR_W-1:0]   r_clr_cnt;
    logic                r_clr_reply;
    logic [VAL_W-1:0]    r_res_value;
    logic                r_res_acc;
    t_div_req            r_div_req;

    logic                r_out_valid;
    logic [VAL_W-1:0]    r_out_value;
    logic [9:0]          r_out_high;
    logic                r_out_acc;

    t_div_rsp            div_rsp;
    t_mem_wr             mem_wr;
    logic                rd_en;
    logic [VAL_W-1:0]    rd_data;
    logic [CNT_W-1:0]    bins_use;
    logic [BCNT_W-1:0]   bands_use;
    logic                band_ok;
    logic                rbin_ok;
    logic                qbin_ok;
    logic [VAL_W:0]      sum_wide;
    logic [VAL_W-1:0]    sum_sat;
    logic                in_fire;

    // bins and bands in use
    always_comb begin
        bins_use  = (CNT_W'(r_bin_count) < CNT_W'(MAX_BINS)) ? CNT_W'(r_bin_count)
                                                             : CNT_W'(MAX_BINS);
        bands_use = (BCNT_W'(r_band_count) < BCNT_W'(MAX_BANDS)) ? BCNT_W'(r_band_count)
                                                                 : BCNT_W'(MAX_BANDS);
        band_ok   = BCNT_W'(i_band) < bands_use;
        rbin_ok   = CNT_W'(i_read_bin) < bins_use;
        qbin_ok   = div_rsp.quotient < WORD_W'(bins_use);
    end

    // saturating bin update
    always_comb begin
        sum_wide = {1'b0, rd_data} + (VAL_W + 1)'(r_add);
        sum_sat  = sum_wide[VAL_W] ? {VAL_W{1'b1}} : sum_wide[VAL_W-1:0];
    end

    // store ports: clearing sweep or bin update
    always_comb begin
        rd_en = (r_state == ST_RD);
        if (r_state == ST_CLEAR) begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = r_clr_cnt;
            mem_wr.data = '0;
        end else begin
            mem_wr.en   = (r_state == ST_USE) && (r_op == ACT_ACCUM);
            mem_wr.addr = r_addr;
            mem_wr.data = sum_sat;
        end
    end

    assign in_fire = i_in_valid && o_in_ready;

    // sequencer, configuration and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_CLEAR;
            r_bin_width     <= WORD_W'(65);
            r_bin_count     <= 11'd1024;
            r_band_count    <= 4'd8;
            r_highest       <= '0;
            r_clr_cnt       <= '0;
            r_clr_reply     <= 1'b0;
            r_div_req.start <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_div_req.start <= 1'b0;

            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_BIN_WIDTH:  r_bin_width  <= i_cfg_data;
                    CFG_BIN_COUNT:  r_bin_count  <= i_cfg_data[10:0];
                    CFG_BAND_COUNT: r_band_count <= i_cfg_data[3:0];
                    default: ;
                endcase
            end

            // output word taken
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + 1'b1;
                    if (r_clr_cnt == ADDR_W'(DEPTH - 1)) begin
                        r_clr_cnt <= '0;
                        r_state   <= r_clr_reply ? ST_EMIT : ST_IDLE;
                    end
                end

                ST_IDLE: begin
                    if (in_fire) begin
                        r_op        <= t_action'(i_action);
                        r_dist      <= i_path_distance;
                        r_energy    <= i_hit_energy;
                        r_hits      <= i_ray_hit_count;
                        r_band      <= i_band;
                        r_res_value <= '0;
                        r_res_acc   <= 1'b0;
                        r_addr      <= ADDR_W'(i_band) * ADDR_W'(MAX_BINS)
                                     + ADDR_W'(i_read_bin);
                        unique case (t_action'(i_action))
                            ACT_ACCUM: begin
                                if (band_ok) begin
                                    r_div_req.start    <= 1'b1;
                                    r_div_req.dividend <= i_arrival_time;
                                    r_div_req.divisor  <= r_bin_width;
                                    r_state            <= ST_DIV_T;
                                end else begin
                                    r_state <= ST_EMIT;
                                end
                            end
                            ACT_READ: begin
                                r_state <= (band_ok && rbin_ok) ? ST_RD : ST_EMIT;
                            end
                            ACT_CLEAR: begin
                                r_highest   <= '0;
                                r_clr_reply <= 1'b1;
                                r_clr_cnt   <= '0;
                                r_state     <= ST_CLEAR;
                            end
                            ACT_NOP: begin
                                r_state <= ST_EMIT;
                            end
                        endcase
                    end
                end

                // time bin from the shared divider
                ST_DIV_T: begin
                    if (div_rsp.done) begin
                        r_bin  <= div_rsp.quotient[BIN_W-1:0];
                        r_addr <= ADDR_W'(r_band) * ADDR_W'(MAX_BINS)
                                + ADDR_W'(div_rsp.quotient[BIN_W-1:0]);
                        if (!qbin_ok) begin
                            r_state <= ST_EMIT;
                        end else if (r_dist == '0) begin
                            r_add   <= r_energy;
                            r_state <= ST_RD;
                        end else begin
                            r_div_req.start    <= 1'b1;
                            r_div_req.dividend <= r_energy;
                            r_div_req.divisor  <= (r_hits == '0) ? WORD_W'(1)
                                                                 : WORD_W'(r_hits);
                            r_state            <= ST_DIV_E;
                        end
                    end
                end

                // energy share from the shared divider
                ST_DIV_E: begin
                    if (div_rsp.done) begin
                        r_add   <= div_rsp.quotient;
                        r_state <= ST_RD;
                    end
                end

                ST_RD: begin
                    r_state <= ST_USE;
                end

                ST_USE: begin
                    if (r_op == ACT_ACCUM) begin
                        r_res_value <= sum_sat;
                        r_res_acc   <= 1'b1;
                        if (r_bin > r_highest) begin
                            r_highest <= r_bin;
                        end
                    end else begin
                        r_res_value <= rd_data;
                    end
                    r_state <= ST_EMIT;
                end

                ST_EMIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= r_res_value;
                        r_out_high  <= hi_out(r_highest);
                        r_out_acc   <= r_res_acc;
                        r_clr_reply <= 1'b0;
                        r_state     <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    ebin_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (div_rsp)
    );

    ebin_store u_store (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_data)
    );

    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_bin_value   = r_out_value;
    assign o_highest_bin = r_out_high;
    assign o_accepted    = r_out_acc;

endmodule
`default_nettype wire

// ===== design/ebin_checker.sv =====
// ebin_checker: port-level checks for the echogram energy binner
// depends on ebin_pkg for the action codes and on the top-level ports; attached by the bind below
`default_nettype none
module ebin_checker
    import ebin_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic [1:0]  i_action,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [47:0] o_bin_value,
    input wire logic [9:0]  o_highest_bin,
    input wire logic        o_accepted
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_bin_value)
            && $stable(o_highest_bin) && $stable(o_accepted))
        else $error("result word changed while stalled");

    // one word at a time: busy right after taking a word
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while a word is in progress");

    // reset empties the output and starts the clearing pass
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("block not held off after reset");

    // a clear holds the input off while the store is swept
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_action == ACT_CLEAR) |=> !o_in_ready [*16])
        else $error("input taken during the clearing sweep");

endmodule

bind echogram_energy_binner_core ebin_checker u_ebin_checker (.*);
`default_nettype wire

// ===== tb/sv/echogram_checker.sv =====
// echogram_checker: watches the word and result channels of the echogram binner,
// keeps its own copy of the echogram and compares every result word field by field
// depends on ebin_pkg for the store geometry and the action and register codes
module echogram_checker
    import ebin_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [1:0]  i_action,
    input  wire logic [2:0]  i_band,
    input  wire logic [31:0] i_arrival_time,
    input  wire logic [31:0] i_path_distance,
    input  wire logic [31:0] i_hit_energy,
    input  wire logic [15:0] i_ray_hit_count,
    input  wire logic [9:0]  i_read_bin,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [47:0] i_bin_value,
    input  wire logic [9:0]  i_highest_bin,
    input  wire logic        i_accepted,
    output int               o_fail_count,
    output int               o_pending
);

    localparam logic [VAL_W-1:0] VAL_MAX        = '1;
    localparam logic [31:0]      RST_BIN_WIDTH  = 32'd65;
    localparam logic [10:0]      RST_BIN_COUNT  = 11'd1024;
    localparam logic [3:0]       RST_BAND_COUNT = 4'd8;

    typedef struct packed {
        logic [47:0] bin_value;
        logic [9:0]  highest_bin;
        logic        accepted;
    } t_bin_result;

    // shadow registers and echogram
    logic [31:0]      bin_width_q;
    logic [10:0]      bin_count_q;
    logic [3:0]       band_count_q;
    logic [VAL_W-1:0] energy_shadow [DEPTH];
    int unsigned      highest_q;
    t_bin_result      expected_bins [$];
    int               fail_count = 0;

    // empty echogram, highest mark back to zero
    function automatic void wipe_echogram();
        for (int i = 0; i < DEPTH; i++) begin
            energy_shadow[i] = '0;
        end
        highest_q = 0;
    endfunction

    // apply one word to the shadow echogram and return the result word it should give
    function automatic t_bin_result update_echogram(
        input t_action     act,
        input logic [2:0]  bnd,
        input logic [31:0] stamp,
        input logic [31:0] distance,
        input logic [31:0] energy,
        input logic [15:0] hits,
        input logic [9:0]  rbin
    );
        int unsigned bins_used;
        int unsigned bands_used;
        int unsigned addr;
        logic [31:0] slot;
        logic [31:0] divisor;
        logic [31:0] gain;
        logic [48:0] total;
        t_bin_result r;
        bins_used  = (bin_count_q < MAX_BINS) ? bin_count_q : MAX_BINS;
        bands_used = (band_count_q < MAX_BANDS) ? band_count_q : MAX_BANDS;
        r = '0;
        case (act)
            ACT_ACCUM: begin
                // zero bin width pushes the hit past every bin
                slot = (bin_width_q != 0) ? stamp / bin_width_q : '1;
                if (slot < bins_used && bnd < bands_used) begin
                    // direct hit keeps its full energy, zero hit count divides by one
                    divisor = (hits != 0) ? 32'(hits) : 32'd1;
                    gain    = (distance == 0) ? energy : energy / divisor;
                    addr    = bnd * MAX_BINS + slot;
                    total   = 49'(energy_shadow[addr]) + 49'(gain);
                    if (total > 49'(VAL_MAX)) begin
                        total = 49'(VAL_MAX);
                    end
                    energy_shadow[addr] = total[VAL_W-1:0];
                    if (slot > highest_q) begin
                        highest_q = slot;
                    end
                    r.bin_value = total[VAL_W-1:0];
                    r.accepted  = 1'b1;
                end
            end
            ACT_READ: begin
                // bins and bands outside the range in use read as zero
                if (rbin < bins_used && bnd < bands_used) begin
                    r.bin_value = energy_shadow[bnd * MAX_BINS + rbin];
                end
            end
            ACT_CLEAR: begin
                wipe_echogram();
            end
            default: ;
        endcase
        r.highest_bin = (highest_q > 1023) ? 10'd1023 : 10'(highest_q);
        return r;
    endfunction

    // compare result words, queue predictions, follow register writes
    always @(posedge i_clk) begin : watch
        t_bin_result want;
        if (!i_rst_n) begin
            bin_width_q  = RST_BIN_WIDTH;
            bin_count_q  = RST_BIN_COUNT;
            band_count_q = RST_BAND_COUNT;
            wipe_echogram();
            expected_bins.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_bins.size() == 0) begin
                    $error("result word with nothing expected: bin_value %0h highest_bin %0d",
                           i_bin_value, i_highest_bin);
                    fail_count++;
                end else begin
                    want = expected_bins.pop_front();
                    if (i_bin_value !== want.bin_value) begin
                        $error("bin_value: expected %0h, got %0h", want.bin_value, i_bin_value);
                        fail_count++;
                    end
                    if (i_highest_bin !== want.highest_bin) begin
                        $error("highest_bin: expected %0d, got %0d",
                               want.highest_bin, i_highest_bin);
                        fail_count++;
                    end
                    if (i_accepted !== want.accepted) begin
                        $error("accepted: expected %0b, got %0b", want.accepted, i_accepted);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                want = update_echogram(t_action'(i_action), i_band,
                    i_arrival_time, i_path_distance, i_hit_energy, i_ray_hit_count,
                    i_read_bin);
                expected_bins.insert(expected_bins.size(), want);
            end
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_BIN_WIDTH:  bin_width_q  = i_cfg_data;
                    CFG_BIN_COUNT:  bin_count_q  = i_cfg_data[10:0];
                    CFG_BAND_COUNT: band_count_q = i_cfg_data[3:0];
                    default: ;
                endcase
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_bins.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
// testbench: drives hit, read and clear words into the echogram binner through several
// register settings and pacing patterns; checking is left to echogram_checker
// depends on ebin_pkg, echogram_checker and echogram_energy_binner_core
module testbench;
    import ebin_pkg::*;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 50000;
    localparam int SETTLE_CYCLES  = 100;

    typedef struct {
        t_action     action;
        logic [2:0]  band;
        logic [31:0] arrival;
        logic [31:0] distance;
        logic [31:0] energy;
        logic [15:0] hits;
        logic [9:0]  rbin;
    } t_hit_word;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [1:0]  cfg_index     = '0;
    logic [31:0] cfg_data      = '0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic [1:0]  action        = '0;
    logic [2:0]  band          = '0;
    logic [31:0] arrival_time  = '0;
    logic [31:0] path_distance = '0;
    logic [31:0] hit_energy    = '0;
    logic [15:0] ray_hit_count = '0;
    logic [9:0]  read_bin      = '0;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic [47:0] bin_value;
    logic [9:0]  highest_bin;
    logic        accepted;

    int fail_count;
    int pending_words;

    // pacing, and the long receiver hold-off
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_orders  = 0;
    int hold_taken   = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    // register values last written, used only to aim the stimulus
    logic [31:0] cur_width = 32'd65;
    logic [10:0] cur_count = 11'd1024;
    logic [3:0]  cur_bands = 4'd8;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    echogram_energy_binner_core uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_action        (action),
        .i_band          (band),
        .i_arrival_time  (arrival_time),
        .i_path_distance (path_distance),
        .i_hit_energy    (hit_energy),
        .i_ray_hit_count (ray_hit_count),
        .i_read_bin      (read_bin),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_bin_value     (bin_value),
        .o_highest_bin   (highest_bin),
        .o_accepted      (accepted)
    );

    echogram_checker checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_action        (action),
        .i_band          (band),
        .i_arrival_time  (arrival_time),
        .i_path_distance (path_distance),
        .i_hit_energy    (hit_energy),
        .i_ray_hit_count (ray_hit_count),
        .i_read_bin      (read_bin),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_bin_value     (bin_value),
        .i_highest_bin   (highest_bin),
        .i_accepted      (accepted),
        .o_fail_count    (fail_count),
        .o_pending       (pending_words)
    );

    // receiver: random stalls, or a counted hold-off when one is ordered
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_taken != hold_orders) begin
            out_ready  <= 1'b0;
            hold_taken <= hold_taken + 1;
            hold_left  <= HOLD_CYCLES;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // watchdog on cycles in which neither channel moves a word
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic t_hit_word hit_word(
        input t_action     act,
        input logic [2:0]  bnd,
        input logic [31:0] stamp,
        input logic [31:0] distance,
        input logic [31:0] energy,
        input logic [15:0] hits,
        input logic [9:0]  rbin
    );
        t_hit_word w;
        w.action   = act;
        w.band     = bnd;
        w.arrival  = stamp;
        w.distance = distance;
        w.energy   = energy;
        w.hits     = hits;
        w.rbin     = rbin;
        return w;
    endfunction

    // mostly a few low bins so hits pile up, sometimes anywhere, now and then just past the end
    function automatic int unsigned pick_slot(input int unsigned span);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (span == 0) begin
            return $urandom_range(0, 1023);
        end
        if (r < 60) begin
            return $urandom_range(0, ((span < 8) ? span : 8) - 1);
        end
        if (r < 90) begin
            return $urandom_range(0, span - 1);
        end
        return span + $urandom_range(0, 3);
    endfunction

    function automatic t_hit_word random_hit_word();
        t_hit_word       w;
        int unsigned     span;
        int unsigned     lanes;
        int unsigned     r;
        longint unsigned stamp;
        span  = (cur_count < MAX_BINS) ? cur_count : MAX_BINS;
        lanes = (cur_bands < MAX_BANDS) ? cur_bands : MAX_BANDS;
        r = $urandom_range(0, 99);
        w.action = (r < 75) ? ACT_ACCUM : (r < 97) ? ACT_READ : ACT_NOP;
        if (lanes != 0 && $urandom_range(0, 99) < 85) begin
            w.band = 3'($urandom_range(0, lanes - 1));
        end else begin
            w.band = 3'($urandom_range(0, 7));
        end
        // arrival time aimed at a chosen bin, or anything at all
        if (cur_width != 0 && $urandom_range(0, 99) < 85) begin
            stamp = pick_slot(span);
            stamp = stamp * cur_width + $urandom_range(0, cur_width - 1);
            w.arrival = (stamp > 64'hFFFF_FFFF) ? $urandom() : stamp[31:0];
        end else begin
            w.arrival = $urandom();
        end
        r = $urandom_range(0, 99);
        w.distance = (r < 35) ? 32'd0 : (r < 50) ? $urandom_range(1, 3) : $urandom();
        r = $urandom_range(0, 99);
        w.energy = (r < 20) ? 32'hFFFF_FFFF : (r < 50) ? $urandom_range(0, 1000) : $urandom();
        r = $urandom_range(0, 99);
        w.hits = (r < 10) ? 16'd0 : (r < 50) ? 16'($urandom_range(1, 8)) : 16'($urandom());
        w.rbin = ($urandom_range(0, 99) < 75) ? 10'(pick_slot(span)) : 10'($urandom());
        return w;
    endfunction

    // offer one word and hold it until taken; valid stays up for a following word
    task automatic send_word(input t_hit_word w);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 100)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        action        <= w.action;
        band          <= w.band;
        arrival_time  <= w.arrival;
        path_distance <= w.distance;
        hit_energy    <= w.energy;
        ray_hit_count <= w.hits;
        read_bin      <= w.rbin;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [31:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // one register setting, one pacing pattern, a run of random words
    task automatic run_phase(
        input logic [31:0] width,
        input logic [10:0] count,
        input logic [3:0]  bands,
        input int          tx_pct,
        input int          rx_pct,
        input int          n_words,
        input bit          with_clear,
        input bit          with_hold
    );
        t_hit_word w;
        write_reg(CFG_BIN_WIDTH, width);
        write_reg(CFG_BIN_COUNT, 32'(count));
        write_reg(CFG_BAND_COUNT, 32'(bands));
        cur_width    = width;
        cur_count    = count;
        cur_bands    = bands;
        tx_idle_pct  = tx_pct;
        rx_stall_pct <= rx_pct;
        for (int i = 0; i < n_words; i++) begin
            if (with_hold && (i == 0 || i == n_words / 2)) begin
                hold_orders <= hold_orders + 1;
            end
            if (with_clear && i == n_words / 2) begin
                w = hit_word(ACT_CLEAR, 3'd0, '0, '0, '0, '0, '0);
            end else begin
                w = random_hit_word();
            end
            send_word(w);
        end
        wait_results();
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed words on the reset register values, bin width 65
        send_word(hit_word(ACT_READ,  3'd0, 32'd0, 32'd0, 32'd0, 16'd0, 10'd0));
        // direct hit with the largest energy
        send_word(hit_word(ACT_ACCUM, 3'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 16'd0, 10'd0));
        // zero hit count adds the full energy
        send_word(hit_word(ACT_ACCUM, 3'd0, 32'd64, 32'd1, 32'd1000, 16'd0, 10'd0));
        send_word(hit_word(ACT_ACCUM, 3'd0, 32'd65, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           16'hFFFF, 10'd0));
        // last bin in use moves the highest mark to the top
        send_word(hit_word(ACT_ACCUM, 3'd7, 32'd66495, 32'd5, 32'h1234_5678, 16'd3, 10'd0));
        // one past the last bin, and the latest arrival time: both dropped
        send_word(hit_word(ACT_ACCUM, 3'd7, 32'd66560, 32'd0, 32'd77, 16'd1, 10'd0));
        send_word(hit_word(ACT_ACCUM, 3'd0, 32'hFFFF_FFFF, 32'd0, 32'd77, 16'd1, 10'd0));
        send_word(hit_word(ACT_ACCUM, 3'd7, 32'd0, 32'd9, 32'd0, 16'd1, 10'd0));
        send_word(hit_word(ACT_READ,  3'd0, 32'd0, 32'd0, 32'd0, 16'd0, 10'd0));
        send_word(hit_word(ACT_READ,  3'd0, 32'd0, 32'd0, 32'd0, 16'd0, 10'd1));
        send_word(hit_word(ACT_READ,  3'd7, 32'd0, 32'd0, 32'd0, 16'd0, 10'd1023));
        send_word(hit_word(ACT_READ,  3'd3, 32'd0, 32'd0, 32'd0, 16'd0, 10'd512));
        // spare action code, every other field all ones
        send_word(hit_word(ACT_NOP, 3'd7, '1, '1, '1, '1, '1));
        send_word(hit_word(ACT_CLEAR, 3'd0, '0, '0, '0, '0, '0));
        send_word(hit_word(ACT_READ,  3'd7, 32'd0, 32'd0, 32'd0, 16'd0, 10'd1023));
        send_word(hit_word(ACT_ACCUM, 3'd5, 32'd130, 32'd0, 32'd1, 16'd2, 10'd0));
        send_word(hit_word(ACT_READ,  3'd5, 32'd0, 32'd0, 32'd0, 16'd0, 10'd2));
        wait_results();

        // random words over several settings, extremes among them
        run_phase(32'h0001_0000, 11'd1024, 4'd8, 0, 0, 180, 1'b1, 1'b0);
        run_phase(32'd1, 11'd16, 4'd3, 72, 0, 150, 1'b0, 1'b0);
        run_phase(32'hFFFF_FFFF, 11'd2047, 4'd15, 0, 72, 150, 1'b1, 1'b0);
        run_phase(32'h0001_2345, 11'd1, 4'd1, 14, 14, 120, 1'b0, 1'b0);
        // receiver held off while words keep coming
        run_phase(32'd1000, 11'd100, 4'd8, 0, 0, 100, 1'b1, 1'b1);
        // zero bin width, no bins and no bands in use
        run_phase(32'd0, 11'd0, 4'd0, 72, 72, 30, 1'b0, 1'b0);
        run_phase($urandom_range(1, 4000), 11'($urandom_range(1, 1024)),
                  4'($urandom_range(1, 8)), 14, 14, 100, 1'b0, 1'b0);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
